// ===== hw/rtl/swfe_pkg.sv =====
// Shared types and constants for the sync word frame extractor.
package swfe_pkg;

    localparam int unsigned SYMBOL_W   = 8;
    localparam int unsigned FRAME_W    = 16;
    localparam int unsigned SYNC_LEN_W = 7;
    localparam int unsigned BPS_W      = 4;
    localparam int unsigned HISTORY_W  = 64;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PROD_W     = SYNC_LEN_W + BPS_W;

    localparam logic [FRAME_W-1:0]    FRAME_LENGTH_RST = 16'd480;
    localparam logic [SYNC_LEN_W-1:0] SYNC_LENGTH_RST  = 7'd20;
    localparam logic [BPS_W-1:0]      BPS_RST          = 4'd2;
    localparam logic [HISTORY_W-1:0]  SYNC_PATTERN_RST = 64'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH    = 2'd0,
        CFG_SYNC_LENGTH     = 2'd1,
        CFG_BITS_PER_SYMBOL = 2'd2,
        CFG_SYNC_PATTERN    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame_length;
        logic [SYNC_LEN_W-1:0] sync_length;
        logic [BPS_W-1:0]      bits_per_symbol;
        logic [HISTORY_W-1:0]  sync_pattern;
    } t_cfg;

    // One result beat handed from the frame logic to the output register.
    typedef struct packed {
        logic                valid;
        logic [SYMBOL_W-1:0] symbol;
    } t_beat;

endpackage

// ===== hw/rtl/swfe_if.sv =====
// Stream interfaces for the symbol input and output channels.
interface swfe_in_if;
    logic                          valid;
    logic                          ready;
    logic [swfe_pkg::SYMBOL_W-1:0] in_symbol;

    modport source (output valid, output in_symbol, input ready);
    modport sink   (input valid, input in_symbol, output ready);
endinterface

interface swfe_out_if;
    logic                          valid;
    logic                          ready;
    logic [swfe_pkg::SYMBOL_W-1:0] out_symbol;

    modport source (output valid, output out_symbol, input ready);
    modport sink   (input valid, input out_symbol, output ready);
endinterface

// ===== hw/rtl/sync_word_frame_extractor.sv =====
// Top level of the sync word frame extractor.
//
// Symbol bytes arrive as beats on i_sym; frame payload bytes leave as beats
// on o_sym. While hunting, each beat is checked against the sync pattern:
// the history of past symbols is masked to sync_length*bits_per_symbol bits
// and compared; a miss shifts the symbol's low bits into the history and
// gives no output, a hit passes the byte on and arms a frame count of
// frame_length-1. Payload bytes then pass through until sync_length counts
// remain, and those last symbols are gathered silently for the next check.
// Configuration is written via i_cfg_we/i_cfg_idx/i_cfg_data while idle; the
// user must keep to that, the block does not enforce it. Throughput is one
// beat per cycle unless output stalls: one frame state update per symbol.
// An output beat shows in the cycle after its input beat. The only buffer is
// the output register; i_sym.ready falls while a held beat is stalled. Reset
// clears the history and count and restores the default register values.
module sync_word_frame_extractor #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swfe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swfe_in_if.sink                         i_sym,
    swfe_out_if.source                      o_sym
);

    swfe_pkg::t_cfg  cfg;
    swfe_pkg::t_beat beat;
    logic            space;
    logic            accept;

    swfe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (swfe_pkg::t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Input beats are taken whenever the output register can absorb a result.
    assign i_sym.ready = space;
    assign accept      = i_sym.valid && space;

    swfe_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_symbol (i_sym.in_symbol),
        .i_cfg    (cfg),
        .o_beat   (beat)
    );

    swfe_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .o_space (space),
        .o_sym   (o_sym)
    );

`ifndef NO_ASSERTIONS
    // A result produced by an accepted beat is visible on the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat.valid |=> o_sym.valid)
        else $error("result beat not presented after acceptance");

    // The core only produces results for accepted beats.
    a_result_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat.valid |-> accept)
        else $error("result beat without an accepted input");

    // Input back-pressure only while a held result is stalled.
    a_ready_only_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sym.ready |-> (o_sym.valid && !o_sym.ready))
        else $error("input stalled without a stalled output");

    // Nothing is presented in the cycle after a reset edge.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_sym.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== hw/rtl/swfe_cfg.sv =====
// Configuration register bank of the sync word frame extractor.
module swfe_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  swfe_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [swfe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output swfe_pkg::t_cfg                  o_cfg
);

    swfe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length    <= swfe_pkg::FRAME_LENGTH_RST;
            r_cfg.sync_length     <= swfe_pkg::SYNC_LENGTH_RST;
            r_cfg.bits_per_symbol <= swfe_pkg::BPS_RST;
            r_cfg.sync_pattern    <= swfe_pkg::SYNC_PATTERN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swfe_pkg::CFG_FRAME_LENGTH: begin
                    r_cfg.frame_length <= i_cfg_data[swfe_pkg::FRAME_W-1:0];
                end
                swfe_pkg::CFG_SYNC_LENGTH: begin
                    r_cfg.sync_length <= i_cfg_data[swfe_pkg::SYNC_LEN_W-1:0];
                end
                swfe_pkg::CFG_BITS_PER_SYMBOL: begin
                    r_cfg.bits_per_symbol <= i_cfg_data[swfe_pkg::BPS_W-1:0];
                end
                swfe_pkg::CFG_SYNC_PATTERN: begin
                    r_cfg.sync_pattern <= i_cfg_data[swfe_pkg::HISTORY_W-1:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/swfe_core.sv =====
// Frame state: symbol history, remaining count and the per-beat decision.
module swfe_core #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [swfe_pkg::SYMBOL_W-1:0] i_symbol,
    input  swfe_pkg::t_cfg                i_cfg,
    output swfe_pkg::t_beat               o_beat
);

    localparam int unsigned LOAD_W = (COUNT_BITS > swfe_pkg::FRAME_W) ?
                                     COUNT_BITS : swfe_pkg::FRAME_W;

    logic [swfe_pkg::HISTORY_W-1:0] r_history, n_history;
    logic [COUNT_BITS-1:0]          r_count, n_count;

    logic [swfe_pkg::PROD_W-1:0]    mask_bits;
    logic [swfe_pkg::HISTORY_W-1:0] cmp_mask;
    logic                           sync_hit;
    logic [swfe_pkg::SYMBOL_W-1:0]  sym_mask;
    logic [swfe_pkg::HISTORY_W-1:0] shifted;
    logic [swfe_pkg::FRAME_W-1:0]   frame_m1;
    logic [LOAD_W-1:0]              load_wide;
    logic [LOAD_W-1:0]              count_max_wide;
    logic [COUNT_BITS-1:0]          load_val;
    logic                           in_payload;
    logic                           in_gather;

    // Compare mask: low sync_length*bits_per_symbol bits, all ones from 64 up.
    always_comb begin
        mask_bits = swfe_pkg::PROD_W'(i_cfg.sync_length) *
                    swfe_pkg::PROD_W'(i_cfg.bits_per_symbol);
        if (mask_bits >= swfe_pkg::PROD_W'(swfe_pkg::HISTORY_W)) begin
            cmp_mask = '1;
        end else begin
            cmp_mask = (swfe_pkg::HISTORY_W'(1) << mask_bits[5:0]) -
                       swfe_pkg::HISTORY_W'(1);
        end
        sync_hit = ((r_history & cmp_mask) == i_cfg.sync_pattern);
    end

    // Symbol bits shifted into the history; eight or more keeps the whole byte.
    always_comb begin
        if (i_cfg.bits_per_symbol >= swfe_pkg::BPS_W'(swfe_pkg::SYMBOL_W)) begin
            sym_mask = '1;
        end else begin
            sym_mask = swfe_pkg::SYMBOL_W'((9'd1 << i_cfg.bits_per_symbol) - 9'd1);
        end
        shifted = (r_history << i_cfg.bits_per_symbol) |
                  swfe_pkg::HISTORY_W'(i_symbol & sym_mask);
    end

    // Counter load: frame_length minus one, a zero length counts as one,
    // saturated at the counter's maximum.
    always_comb begin
        frame_m1       = (i_cfg.frame_length == '0) ? '0 :
                         i_cfg.frame_length - swfe_pkg::FRAME_W'(1);
        load_wide      = LOAD_W'(frame_m1);
        count_max_wide = LOAD_W'({COUNT_BITS{1'b1}});
        if (load_wide > count_max_wide) begin
            load_val = COUNT_BITS'(count_max_wide);
        end else begin
            load_val = COUNT_BITS'(load_wide);
        end
    end

    assign in_payload = (r_count > COUNT_BITS'(i_cfg.sync_length));
    assign in_gather  = (r_count != '0);

    always_comb begin
        n_history     = r_history;
        n_count       = r_count;
        o_beat.valid  = 1'b0;
        o_beat.symbol = i_symbol;
        if (i_accept) begin
            priority if (in_payload) begin
                o_beat.valid = 1'b1;
                n_count      = r_count - COUNT_BITS'(1);
            end else if (in_gather) begin
                n_history = shifted;
                n_count   = r_count - COUNT_BITS'(1);
            end else if (!sync_hit) begin
                n_history = shifted;
            end else begin
                o_beat.valid = 1'b1;
                n_count      = load_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history <= '0;
            r_count   <= '0;
        end else begin
            r_history <= n_history;
            r_count   <= n_count;
        end
    end

endmodule

// ===== hw/rtl/swfe_out.sv =====
// Output register that holds one result beat until the receiver takes it.
module swfe_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swfe_pkg::t_beat    i_beat,
    output logic               o_space,
    swfe_out_if.source         o_sym
);

    logic                          r_valid;
    logic [swfe_pkg::SYMBOL_W-1:0] r_symbol;

    // Room for a new beat when empty or when the held beat leaves this cycle.
    assign o_space = !r_valid || o_sym.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_beat.valid) begin
            r_symbol <= i_beat.symbol;
        end
    end

    assign o_sym.valid      = r_valid;
    assign o_sym.out_symbol = r_symbol;

endmodule

// ===== test/tb_sync_word_frame_extractor.sv =====
// Self-checking testbench for the sync word frame extractor with a payload scoreboard.
`timescale 1ns / 100ps

module tb_sync_word_frame_extractor;

    localparam int unsigned COUNT_BITS      = 16;
    localparam int unsigned CLK_PERIOD      = 4;
    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned MAX_GAP         = 17;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned TOTAL_SYMBOLS   = 1850;
    localparam int unsigned FINAL_SYMBOLS   = 60;
    localparam int unsigned RUN_LIMIT_NS    = 2_000_000;
    localparam logic [63:0] COUNT_MAX       = (64'd1 << COUNT_BITS) - 64'd1;

    // Tracks the frame state of the block and the payload bytes it owes the receiver.
    class frame_scoreboard;
        logic [swfe_pkg::FRAME_W-1:0]    frame_length;
        logic [swfe_pkg::SYNC_LEN_W-1:0] sync_length;
        logic [swfe_pkg::BPS_W-1:0]      bits_per_symbol;
        logic [swfe_pkg::HISTORY_W-1:0]  sync_pattern;
        logic [swfe_pkg::HISTORY_W-1:0]  history;
        logic [COUNT_BITS-1:0]           symbols_left;
        logic [swfe_pkg::SYMBOL_W-1:0]   payload_due[$];
        int unsigned                     mismatches;
        int unsigned                     beats_in;
        int unsigned                     beats_out;

        function new();
            frame_length    = swfe_pkg::FRAME_LENGTH_RST;
            sync_length     = swfe_pkg::SYNC_LENGTH_RST;
            bits_per_symbol = swfe_pkg::BPS_RST;
            sync_pattern    = swfe_pkg::SYNC_PATTERN_RST;
            history         = '0;
            symbols_left    = '0;
            mismatches      = 0;
            beats_in        = 0;
            beats_out       = 0;
        endfunction

        function void write_register(swfe_pkg::t_cfg_idx idx,
                                     logic [swfe_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                swfe_pkg::CFG_FRAME_LENGTH:
                    frame_length    = data[swfe_pkg::FRAME_W-1:0];
                swfe_pkg::CFG_SYNC_LENGTH:
                    sync_length     = data[swfe_pkg::SYNC_LEN_W-1:0];
                swfe_pkg::CFG_BITS_PER_SYMBOL:
                    bits_per_symbol = data[swfe_pkg::BPS_W-1:0];
                swfe_pkg::CFG_SYNC_PATTERN:
                    sync_pattern    = data[swfe_pkg::HISTORY_W-1:0];
                default: ;
            endcase
        endfunction

        // Low sync_length*bits_per_symbol bits, all ones once that reaches the word size.
        function logic [swfe_pkg::HISTORY_W-1:0] sync_mask();
            int unsigned width;
            width = int'(sync_length) * int'(bits_per_symbol);
            if (width >= swfe_pkg::HISTORY_W)
                sync_mask = '1;
            else
                sync_mask = (64'd1 << width) - 64'd1;
        endfunction

        function void gather(logic [swfe_pkg::SYMBOL_W-1:0] sym);
            logic [swfe_pkg::HISTORY_W-1:0] keep;
            keep    = (64'd1 << bits_per_symbol) - 64'd1;
            history = (history << bits_per_symbol) | ({56'd0, sym} & keep);
        endfunction

        function void accept_symbol(logic [swfe_pkg::SYMBOL_W-1:0] sym);
            logic [swfe_pkg::FRAME_W-1:0] load;
            beats_in++;
            if (symbols_left > sync_length) begin
                payload_due.push_back(sym);
                symbols_left--;
            end else if (symbols_left != '0) begin
                gather(sym);
                symbols_left--;
            end else if ((history & sync_mask()) != sync_pattern) begin
                gather(sym);
            end else begin
                // Sync hit: this byte opens the frame, the history is left as it is.
                payload_due.push_back(sym);
                load = (frame_length == '0) ? '0 : frame_length - 1'b1;
                symbols_left = (64'(load) > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                                       : COUNT_BITS'(load);
            end
        endfunction

        function void check_payload(logic [swfe_pkg::SYMBOL_W-1:0] sym);
            logic [swfe_pkg::SYMBOL_W-1:0] due;
            beats_out++;
            if (payload_due.size() == 0) begin
                $error("out_symbol: no beat expected, actual %02h", sym);
                mismatches++;
            end else begin
                due = payload_due.pop_front();
                if (sym !== due) begin
                    $error("out_symbol mismatch: expected %02h, actual %02h", due, sym);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            pending = payload_due.size();
        endfunction
    endclass

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [swfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [swfe_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    swfe_in_if  sym_in ();
    swfe_out_if sym_out ();

    frame_scoreboard board = new();

    // The symbols of the sync word of the current setting, oldest first.
    logic [swfe_pkg::SYMBOL_W-1:0] sync_word[$];

    // Idling switches for each side, and the request for one long receiver stall.
    bit          in_idle      = 1'b0;
    bit          out_idle     = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned symbols_sent  = 0;
    int unsigned settings_used = 0;

    sync_word_frame_extractor #(
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sym      (sym_in),
        .o_sym      (sym_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        sym_in.valid     = 1'b0;
        sym_in.in_symbol = '0;
        sym_out.ready    = 1'b0;
    end

    // Every beat is sampled at the rising edge on the values that held through the
    // cycle before it. The input beat is noted first, although its payload beat can
    // only leave in a later cycle, so the order here never matters.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sym_in.valid && sym_in.ready)
                board.accept_symbol(sym_in.in_symbol);
            if (sym_out.valid && sym_out.ready)
                board.check_payload(sym_out.out_symbol);
        end
    end

    // Receiver: before each beat it may hold ready low for a random number of cycles.
    // Once it is asked, it holds off for a long stretch instead, so that the single
    // output register fills and the block has to refuse input beats.
    initial begin : receiver
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                sym_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = out_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                sym_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            sym_out.ready <= 1'b1;
            do @(posedge i_clk); while (!sym_out.valid);
        end
    end

    function automatic logic [swfe_pkg::SYMBOL_W-1:0] random_symbol();
        random_symbol = 8'($urandom_range(0, 255));
    endfunction

    // The history word that the current sync word leaves behind, masked as the
    // block masks it. This is what the pattern register must hold for a hit.
    function automatic logic [swfe_pkg::HISTORY_W-1:0] fold_sync_word(
        input int unsigned sl, input int unsigned bps);
        logic [swfe_pkg::HISTORY_W-1:0] word;
        int unsigned                    width;
        word = '0;
        foreach (sync_word[k])
            word = (word << bps) | ({56'd0, sync_word[k]} & ((64'd1 << bps) - 64'd1));
        width = sl * bps;
        if (width < swfe_pkg::HISTORY_W)
            word &= (64'd1 << width) - 64'd1;
        fold_sync_word = word;
    endfunction

    // Sender: offers one beat, after a random gap when idling is on, and returns at
    // the edge where it is taken. Valid stays high straight into the next beat when
    // no gap is drawn.
    task automatic send_symbol(input logic [swfe_pkg::SYMBOL_W-1:0] value);
        int unsigned gap;
        gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            sym_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sym_in.valid     <= 1'b1;
        sym_in.in_symbol <= value;
        do @(posedge i_clk); while (!sym_in.ready);
        symbols_sent++;
    endtask

    // Waits until every payload beat owed has arrived, then lets the block settle so that
    // a last symbol that gave no beat has surely been taken into the frame state.
    task automatic wait_for_idle();
        sym_in.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic drive_register(input swfe_pkg::t_cfg_idx idx,
                                  input logic [swfe_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_register(idx, data);
    endtask

    // Writes all four registers on consecutive edges; the block must be idle.
    task automatic configure(input logic [swfe_pkg::FRAME_W-1:0] fl,
                             input logic [swfe_pkg::SYNC_LEN_W-1:0] sl,
                             input logic [swfe_pkg::BPS_W-1:0] bps,
                             input logic [swfe_pkg::HISTORY_W-1:0] pattern);
        drive_register(swfe_pkg::CFG_FRAME_LENGTH, swfe_pkg::CFG_DATA_W'(fl));
        drive_register(swfe_pkg::CFG_SYNC_LENGTH, swfe_pkg::CFG_DATA_W'(sl));
        drive_register(swfe_pkg::CFG_BITS_PER_SYMBOL, swfe_pkg::CFG_DATA_W'(bps));
        drive_register(swfe_pkg::CFG_SYNC_PATTERN, pattern);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // The sync word, with the odd symbol spoilt so that some checks miss.
    task automatic send_sync_word();
        foreach (sync_word[k])
            send_symbol(($urandom_range(0, 19) == 0) ? random_symbol() : sync_word[k]);
    endtask

    // A well-formed stream for one setting: sync word, then frames whose payload is
    // random and whose closing sync_length symbols are the next sync word. Junk
    // between frames and the occasional wrong pattern knock the block back to hunting.
    task automatic run_phase(input logic [swfe_pkg::FRAME_W-1:0] fl,
                             input logic [swfe_pkg::SYNC_LEN_W-1:0] sl,
                             input logic [swfe_pkg::BPS_W-1:0] bps,
                             input int unsigned budget, input bit ones_word);
        logic [swfe_pkg::HISTORY_W-1:0] pattern;
        int unsigned                    body;
        int unsigned                    start;
        sync_word.delete();
        for (int k = 0; k < int'(sl); k++)
            sync_word.push_back(random_symbol() | {7'd0, ones_word});
        pattern = fold_sync_word(sl, bps);
        if (!ones_word && $urandom_range(0, 9) == 0)
            pattern ^= 64'd1 << $urandom_range(0, swfe_pkg::HISTORY_W - 1);
        configure(fl, sl, bps, pattern);
        // A frame shorter than its sync word gives only its opening byte.
        body  = (fl > sl) ? int'(fl - sl) : 1;
        start = symbols_sent;
        send_sync_word();
        while (symbols_sent - start < budget) begin
            if ($urandom_range(0, 7) == 0)
                in_idle = !in_idle;
            if ($urandom_range(0, 7) == 0)
                out_idle = !out_idle;
            for (int b = 0; b < body && symbols_sent - start < budget; b++)
                send_symbol(random_symbol());
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) send_symbol(random_symbol());
            send_sync_word();
        end
        wait_for_idle();
    endtask

    // Mostly short sync words, ordinary symbol widths and short frames, with the
    // empty, wide and saturating cases mixed in now and then.
    task automatic run_random_phase();
        logic [swfe_pkg::SYNC_LEN_W-1:0] sl;
        logic [swfe_pkg::BPS_W-1:0]      bps;
        logic [swfe_pkg::FRAME_W-1:0]    fl;
        case ($urandom_range(0, 9))
            0:       sl = '0;
            1:       sl = 7'($urandom_range(20, 64));
            default: sl = 7'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0:       bps = '0;
            1:       bps = 4'($urandom_range(9, 15));
            default: bps = 4'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 4) == 0)
            fl = 16'($urandom_range(0, int'(sl)));
        else
            fl = 16'(int'(sl) + $urandom_range(1, 16));
        run_phase(fl, sl, bps, $urandom_range(60, 160), 1'b0);
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the zero pattern matches the cleared history at once, so
        // the first beat opens a 480-symbol frame. Byte extremes lead it off; the
        // receiver later stalls for a long stretch while payload is flowing.
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_symbol(8'h80);
        send_symbol(8'h01);
        for (int k = 4; k < int'(swfe_pkg::FRAME_LENGTH_RST); k++) begin
            if (k == 120)
                hold_off_req = 1'b1;
            if (k == 200) begin
                in_idle  = 1'b1;
                out_idle = 1'b1;
            end
            send_symbol(random_symbol());
        end
        wait_for_idle();

        // A one-byte sync word and three-symbol frames: miss, hit, payload, the
        // silently gathered sync byte, a second hit, then the frame run out.
        configure(16'd3, 7'd1, 4'd8, 64'hA5);
        send_symbol(8'hA5);
        send_symbol(8'h12);
        send_symbol(8'h34);
        send_symbol(8'hA5);
        send_symbol(8'h77);
        send_symbol(8'h00);
        send_symbol(8'h5A);
        wait_for_idle();

        // Zero frame length acts as one: each hit passes a single byte and, as the
        // history does not move on a hit, the next beat hits again.
        configure(16'd0, 7'd1, 4'd8, 64'h3C);
        send_symbol(8'h3C);
        send_symbol(8'hC3);
        send_symbol(8'h3C);
        wait_for_idle();

        // No bits per symbol: an empty mask, a zero pattern hits and nothing shifts.
        configure(16'd2, 7'd3, 4'd0, 64'd0);
        send_symbol(8'hFF);
        send_symbol(8'h00);
        send_symbol(8'h55);
        wait_for_idle();

        // A pattern bit above the mask: the block must never find a frame.
        configure(16'd2, 7'd3, 4'd0, 64'd1);
        send_symbol(8'hAA);
        send_symbol(8'h01);
        wait_for_idle();

        // A zero sync length also gives an empty mask, and the whole frame passes.
        configure(16'd3, 7'd0, 4'd4, 64'd0);
        send_symbol(8'h0F);
        send_symbol(8'hF0);
        send_symbol(8'h99);
        wait_for_idle();

        // Symbols wider than a byte keep all eight bits while the history moves by
        // twelve; the third beat hits and the last is gathered silently.
        sync_word = '{8'hFF, 8'h81};
        configure(16'd2, 7'd2, 4'd12, fold_sync_word(2, 12));
        send_symbol(8'hFF);
        send_symbol(8'h81);
        send_symbol(8'h42);
        send_symbol(8'h10);
        wait_for_idle();

        // Saturated masks: 64 one-bit symbols against an all-ones pattern, then the
        // longest sync word at the widest symbol, and frames of a single symbol.
        run_phase(16'd70, 7'd64, 4'd1, 150, 1'b1);
        run_phase(16'd130, 7'd127, 4'd15, 128, 1'b0);
        run_phase(16'd1, 7'd3, 4'd2, 60, 1'b0);

        while (symbols_sent < TOTAL_SYMBOLS - FINAL_SYMBOLS)
            run_random_phase();

        // The longest frame: the run ends part-way through its payload.
        run_phase(16'hFFFF, 7'd4, 4'd4, FINAL_SYMBOLS, 1'b0);

        $display("Run covered %0d symbol beats in and %0d payload beats out over %0d settings,",
                 board.beats_in, board.beats_out, settings_used);
        $display("with empty and saturated masks, odd symbol widths and a long output stall.");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("sync_word_frame_extractor test passed");
        else
            $display("sync_word_frame_extractor test failed");
        $finish;
    end

    // A run that hangs on a handshake ends here.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("sync_word_frame_extractor test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/swfe_pkg.sv
hw/rtl/swfe_if.sv
hw/rtl/swfe_cfg.sv
hw/rtl/swfe_core.sv
hw/rtl/swfe_out.sv
hw/rtl/sync_word_frame_extractor.sv
test/tb_sync_word_frame_extractor.sv
